// File: rtl/core/vlf_pkg.sv
// shared constants and types for the video layout fit/fill/crop block
package vlf_pkg;

  localparam int VLF_DIM_BITS = 13;
  localparam int VLF_FRAC_BITS = 16;
  localparam int VLF_SA_BITS = 24;
  localparam int VLF_CFG_BITS = 4;
  localparam int VLF_IDX_BITS = 2;

  // configuration register indexes
  localparam logic [VLF_IDX_BITS-1:0] REG_SCALE_MODE = 2'd0;
  localparam logic [VLF_IDX_BITS-1:0] REG_ASPECT_OVR = 2'd1;
  localparam logic [VLF_IDX_BITS-1:0] REG_CROP_SEL = 2'd2;

  // scale modes; the unused code behaves as fill
  localparam logic [1:0] MODE_FIT = 2'd0;
  localparam logic [1:0] MODE_FILL = 2'd1;
  localparam logic [1:0] MODE_STRETCH = 2'd2;

  // ratio tables as numerator / denominator, zero numerator means no entry
  localparam longint unsigned OVR_NUM [16] = '{0, 1, 4, 16, 16, 221, 235, 239, 5,
                                               0, 0, 0, 0, 0, 0, 0};
  localparam longint unsigned OVR_DEN [16] = '{1, 1, 3, 9, 10, 100, 100, 100, 4,
                                               1, 1, 1, 1, 1, 1, 1};
  localparam longint unsigned CROP_NUM [16] = '{0, 16, 16, 185, 221, 235, 239, 5, 4, 5, 1,
                                                0, 0, 0, 0, 0};
  localparam longint unsigned CROP_DEN [16] = '{1, 10, 9, 100, 100, 100, 100, 3, 3, 4, 1,
                                                1, 1, 1, 1, 1};

  // which rectangle edge the last division adjusts
  typedef enum logic [2:0] {
    OP_NONE,
    OP_DST_H,
    OP_DST_W,
    OP_SRC_W,
    OP_SRC_H
  } op_t;

endpackage

// File: rtl/core/vlf_if.sv
// request and layout channel interfaces
interface vlf_req_if
  import vlf_pkg::*;
#(parameter int DIM_BITS = VLF_DIM_BITS) ();
  logic valid;
  logic ready;
  logic [DIM_BITS-1:0] frame_w;
  logic [DIM_BITS-1:0] frame_h;
  logic [VLF_SA_BITS-1:0] stream_aspect;
  logic [DIM_BITS-1:0] out_w;
  logic [DIM_BITS-1:0] out_h;
  modport source(output valid, frame_w, frame_h, stream_aspect, out_w, out_h, input ready);
  modport sink(input valid, frame_w, frame_h, stream_aspect, out_w, out_h, output ready);
endinterface

interface vlf_rsp_if
  import vlf_pkg::*;
#(parameter int DIM_BITS = VLF_DIM_BITS) ();
  logic valid;
  logic ready;
  logic layout_valid;
  logic [DIM_BITS-1:0] src_x;
  logic [DIM_BITS-1:0] src_y;
  logic [DIM_BITS-1:0] src_w;
  logic [DIM_BITS-1:0] src_h;
  logic [DIM_BITS-1:0] dst_x;
  logic [DIM_BITS-1:0] dst_y;
  logic [DIM_BITS-1:0] dst_w;
  logic [DIM_BITS-1:0] dst_h;
  logic source_cropped;
  modport source(output valid, layout_valid, src_x, src_y, src_w, src_h, dst_x, dst_y, dst_w,
                 dst_h, source_cropped, input ready);
  modport sink(input valid, layout_valid, src_x, src_y, src_w, src_h, dst_x, dst_y, dst_w,
               dst_h, source_cropped, output ready);
endinterface

// File: rtl/core/vlf_div.sv
// pipelined restoring divider, one quotient bit per stage, rounds half up
module vlf_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW:0]   out_q,
  output logic          out_ovf,
  output logic [SW-1:0] out_side
);

  localparam int HW = NW - QW;

  logic          vld  [QW+1];
  logic [DW-1:0] rem  [QW+1];
  logic [QW-1:0] low  [QW];
  logic [QW-1:0] quo  [QW+1];
  logic [DW-1:0] den  [QW+1];
  logic          ovf  [QW+1];
  logic [SW-1:0] side [QW+1];
  logic          rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  // quotient would not fit in QW bits
  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]  <= DW'(in_num[NW-1:QW]);
      low[0]  <= in_num[QW-1:0];
      quo[0]  <= '0;
      den[0]  <= in_den;
      ovf[0]  <= ({{DW{1'b0}}, in_num[NW-1:QW]} >= {{HW{1'b0}}, in_den});
      side[0] <= in_side;
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_stage
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;
    assign t    = {rem[i-1], low[i-1][QW-1]};
    assign diff = t - {1'b0, den[i-1]};
    assign ge   = (t >= {1'b0, den[i-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i]  <= ge ? diff[DW-1:0] : t[DW-1:0];
        quo[i]  <= {quo[i-1][QW-2:0], ge};
        den[i]  <= den[i-1];
        ovf[i]  <= ovf[i-1];
        side[i] <= side[i-1];
      end
    end

    if (i < QW) begin : g_low
      always_ff @(posedge clk) begin
        if (adv) begin
          low[i] <= {low[i-1][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign rnd = ({rem[QW], 1'b0} >= {1'b0, den[QW]});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_q    <= {1'b0, quo[QW]} + (QW+1)'(rnd);
      out_ovf  <= ovf[QW];
      out_side <= side[QW];
    end
  end

endmodule

// File: rtl/core/video_layout_fit_fill_crop.sv
// top level: source and destination rectangles for fit, fill, stretch and crop
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    frame_w frame_h stream_aspect out_w out_h
//   rsp      out  valid/ready    layout_valid src_x..dst_h source_cropped
//   cfg      in   cfg_we         cfg_idx cfg_wdata
//
// one transaction per cycle while rsp is not stalled; the path runs through three chained divider
// pipelines plus three register stages (b, c and the output register).
// rst clears all valid bits and the configuration registers.
// a stall on rsp freezes the whole pipeline; req.ready drops in the same cycle.
module video_layout_fit_fill_crop
  import vlf_pkg::*;
#(
  parameter int DIM_BITS = VLF_DIM_BITS,
  parameter int ASPECT_FRAC_BITS = VLF_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [VLF_IDX_BITS-1:0] cfg_idx,
  input  logic [VLF_CFG_BITS-1:0] cfg_wdata,
  vlf_req_if.sink                 req,
  vlf_rsp_if.source               rsp
);

  localparam int D = DIM_BITS;
  localparam int F = ASPECT_FRAC_BITS;
  localparam int AW = (VLF_SA_BITS > D + F + 1) ? VLF_SA_BITS : D + F + 1;
  localparam int TW = F + 2;
  localparam int NA = D + F + 1;
  localparam int QA = D + F;
  localparam int NB = D + AW;
  localparam int QB = D + 1;
  localparam logic [AW-1:0] ONE_Q = AW'(1) << F;

  localparam logic [TW-1:0] OVR_Q [16] = '{
    TW'(((OVR_NUM[0] << (F + 1)) + OVR_DEN[0]) / (2 * OVR_DEN[0])),
    TW'(((OVR_NUM[1] << (F + 1)) + OVR_DEN[1]) / (2 * OVR_DEN[1])),
    TW'(((OVR_NUM[2] << (F + 1)) + OVR_DEN[2]) / (2 * OVR_DEN[2])),
    TW'(((OVR_NUM[3] << (F + 1)) + OVR_DEN[3]) / (2 * OVR_DEN[3])),
    TW'(((OVR_NUM[4] << (F + 1)) + OVR_DEN[4]) / (2 * OVR_DEN[4])),
    TW'(((OVR_NUM[5] << (F + 1)) + OVR_DEN[5]) / (2 * OVR_DEN[5])),
    TW'(((OVR_NUM[6] << (F + 1)) + OVR_DEN[6]) / (2 * OVR_DEN[6])),
    TW'(((OVR_NUM[7] << (F + 1)) + OVR_DEN[7]) / (2 * OVR_DEN[7])),
    TW'(((OVR_NUM[8] << (F + 1)) + OVR_DEN[8]) / (2 * OVR_DEN[8])),
    TW'(((OVR_NUM[9] << (F + 1)) + OVR_DEN[9]) / (2 * OVR_DEN[9])),
    TW'(((OVR_NUM[10] << (F + 1)) + OVR_DEN[10]) / (2 * OVR_DEN[10])),
    TW'(((OVR_NUM[11] << (F + 1)) + OVR_DEN[11]) / (2 * OVR_DEN[11])),
    TW'(((OVR_NUM[12] << (F + 1)) + OVR_DEN[12]) / (2 * OVR_DEN[12])),
    TW'(((OVR_NUM[13] << (F + 1)) + OVR_DEN[13]) / (2 * OVR_DEN[13])),
    TW'(((OVR_NUM[14] << (F + 1)) + OVR_DEN[14]) / (2 * OVR_DEN[14])),
    TW'(((OVR_NUM[15] << (F + 1)) + OVR_DEN[15]) / (2 * OVR_DEN[15]))
  };

  localparam logic [TW-1:0] CROP_Q [16] = '{
    TW'(((CROP_NUM[0] << (F + 1)) + CROP_DEN[0]) / (2 * CROP_DEN[0])),
    TW'(((CROP_NUM[1] << (F + 1)) + CROP_DEN[1]) / (2 * CROP_DEN[1])),
    TW'(((CROP_NUM[2] << (F + 1)) + CROP_DEN[2]) / (2 * CROP_DEN[2])),
    TW'(((CROP_NUM[3] << (F + 1)) + CROP_DEN[3]) / (2 * CROP_DEN[3])),
    TW'(((CROP_NUM[4] << (F + 1)) + CROP_DEN[4]) / (2 * CROP_DEN[4])),
    TW'(((CROP_NUM[5] << (F + 1)) + CROP_DEN[5]) / (2 * CROP_DEN[5])),
    TW'(((CROP_NUM[6] << (F + 1)) + CROP_DEN[6]) / (2 * CROP_DEN[6])),
    TW'(((CROP_NUM[7] << (F + 1)) + CROP_DEN[7]) / (2 * CROP_DEN[7])),
    TW'(((CROP_NUM[8] << (F + 1)) + CROP_DEN[8]) / (2 * CROP_DEN[8])),
    TW'(((CROP_NUM[9] << (F + 1)) + CROP_DEN[9]) / (2 * CROP_DEN[9])),
    TW'(((CROP_NUM[10] << (F + 1)) + CROP_DEN[10]) / (2 * CROP_DEN[10])),
    TW'(((CROP_NUM[11] << (F + 1)) + CROP_DEN[11]) / (2 * CROP_DEN[11])),
    TW'(((CROP_NUM[12] << (F + 1)) + CROP_DEN[12]) / (2 * CROP_DEN[12])),
    TW'(((CROP_NUM[13] << (F + 1)) + CROP_DEN[13]) / (2 * CROP_DEN[13])),
    TW'(((CROP_NUM[14] << (F + 1)) + CROP_DEN[14]) / (2 * CROP_DEN[14])),
    TW'(((CROP_NUM[15] << (F + 1)) + CROP_DEN[15]) / (2 * CROP_DEN[15]))
  };

  typedef struct packed {
    logic [D-1:0]           fw;
    logic [D-1:0]           fh;
    logic [VLF_SA_BITS-1:0] sa;
  } side_a1_t;

  typedef struct packed {
    logic [D-1:0] ow;
    logic [D-1:0] oh;
  } side_a2_t;

  typedef struct packed {
    logic [D-1:0]  fw;
    logic [D-1:0]  fh;
    logic [D-1:0]  ow;
    logic [D-1:0]  oh;
    logic [AW-1:0] oasp;
    logic [AW-1:0] eff;
    logic          act;
    logic          gt;
    logic          zero;
  } side_b_t;

  typedef struct packed {
    logic [D-1:0] fw;
    logic [D-1:0] fh;
    logic [D-1:0] ow;
    logic [D-1:0] oh;
    logic [D-1:0] sx;
    logic [D-1:0] sy;
    logic [D-1:0] sw;
    logic [D-1:0] sh;
    op_t          op;
    logic [D-1:0] lim;
    logic         zero;
  } side_c_t;

  function automatic logic [D-1:0] clampq(logic [D+1:0] q, logic ovf, logic [D-1:0] lim);
    logic [D+1:0] t;
    t = (q == '0) ? (D+2)'(1) : q;
    if (ovf || t > {2'b00, lim}) begin
      return lim;
    end
    return t[D-1:0];
  endfunction

  logic [1:0] layout_mode;
  logic [3:0] aspect_force_sel;
  logic [3:0] crop_ratio_sel;
  logic       adv;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      layout_mode      <= MODE_FIT;
      aspect_force_sel <= '0;
      crop_ratio_sel   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SCALE_MODE: layout_mode <= cfg_wdata[1:0];
        REG_ASPECT_OVR: aspect_force_sel <= cfg_wdata;
        REG_CROP_SEL:   crop_ratio_sel <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic rsp_valid;
  assign adv = !rsp_valid || rsp.ready;
  assign req.ready = adv;

  // stage a: stream aspect and output aspect
  side_a1_t a1_in, a1_out;
  side_a2_t a2_in, a2_out;
  logic [QA:0] disp_q, oasp_q;
  logic a1_valid, a2_valid, a1_ovf, a2_ovf;

  assign a1_in = '{fw: req.frame_w, fh: req.frame_h, sa: req.stream_aspect};
  assign a2_in = '{ow: req.out_w, oh: req.out_h};

  vlf_div #(.NW(NA), .DW(D), .QW(QA), .SW($bits(side_a1_t))) u_div_disp (
    .clk, .rst, .adv,
    .in_valid (req.valid),
    .in_num   (NA'(req.frame_w) << F),
    .in_den   (req.frame_h),
    .in_side  (a1_in),
    .out_valid(a1_valid),
    .out_q    (disp_q),
    .out_ovf  (a1_ovf),
    .out_side (a1_out)
  );

  vlf_div #(.NW(NA), .DW(D), .QW(QA), .SW($bits(side_a2_t))) u_div_oasp (
    .clk, .rst, .adv,
    .in_valid (req.valid),
    .in_num   (NA'(req.out_w) << F),
    .in_den   (req.out_h),
    .in_side  (a2_in),
    .out_valid(a2_valid),
    .out_q    (oasp_q),
    .out_ovf  (a2_ovf),
    .out_side (a2_out)
  );

  // stage b: effective aspect and table crop operands
  logic [AW-1:0] disp, oasp, crop_q, ovr_q, b_den_next;
  logic [NB-1:0] b_prod_next;
  side_b_t       b_side_next;
  logic          b_gt;

  always_comb begin
    disp   = (a1_out.sa != '0) ? AW'(a1_out.sa) :
             ((disp_q == '0 || a1_ovf) ? AW'(1) : AW'(disp_q));
    oasp   = (oasp_q == '0 || a2_ovf) ? AW'(1) : AW'(oasp_q);
    crop_q = AW'(CROP_Q[crop_ratio_sel]);
    ovr_q  = AW'(OVR_Q[aspect_force_sel]);
    b_gt   = disp > crop_q;
    b_side_next.fw   = a1_out.fw;
    b_side_next.fh   = a1_out.fh;
    b_side_next.ow   = a2_out.ow;
    b_side_next.oh   = a2_out.oh;
    b_side_next.oasp = oasp;
    b_side_next.eff  = (ovr_q != '0) ? ovr_q : ((crop_q != '0) ? crop_q : disp);
    b_side_next.act  = (crop_q != '0) && (crop_q != disp);
    b_side_next.gt   = b_gt;
    b_side_next.zero = (a1_out.fw == '0) || (a1_out.fh == '0) ||
                       (a2_out.ow == '0) || (a2_out.oh == '0);
    b_prod_next = b_gt ? NB'(a1_out.fw) * NB'(crop_q) : NB'(a1_out.fh) * NB'(disp);
    b_den_next  = b_gt ? disp : crop_q;
  end

  logic          b_valid;
  logic [NB-1:0] b_prod;
  logic [AW-1:0] b_den;
  side_b_t       b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a1_valid && a2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_prod <= b_prod_next;
      b_den  <= b_den_next;
      b_side <= b_side_next;
    end
  end

  logic          bq_valid, bq_ovf;
  logic [QB:0]   bq;
  side_b_t       bq_side;

  vlf_div #(.NW(NB), .DW(AW), .QW(QB), .SW($bits(side_b_t))) u_div_crop (
    .clk, .rst, .adv,
    .in_valid (b_valid),
    .in_num   (b_prod),
    .in_den   (b_den),
    .in_side  (b_side),
    .out_valid(bq_valid),
    .out_q    (bq),
    .out_ovf  (bq_ovf),
    .out_side (bq_side)
  );

  // stage c: apply table crop, set up fit or fill division (no division for stretch)
  side_c_t       c_side_next;
  logic [D-1:0]  cv, c_a;
  logic [AW-1:0] c_b, c_den_next;

  always_comb begin
    c_side_next.fw   = bq_side.fw;
    c_side_next.fh   = bq_side.fh;
    c_side_next.ow   = bq_side.ow;
    c_side_next.oh   = bq_side.oh;
    c_side_next.zero = bq_side.zero;
    c_side_next.sx   = '0;
    c_side_next.sy   = '0;
    c_side_next.sw   = bq_side.fw;
    c_side_next.sh   = bq_side.fh;
    cv = clampq(bq, bq_ovf, bq_side.gt ? bq_side.fw : bq_side.fh);
    if (bq_side.act) begin
      if (bq_side.gt) begin
        c_side_next.sx = (bq_side.fw - cv) >> 1;
        c_side_next.sw = cv;
      end else begin
        c_side_next.sy = (bq_side.fh - cv) >> 1;
        c_side_next.sh = cv;
      end
    end
    c_side_next.op  = OP_NONE;
    c_side_next.lim = '0;
    c_a        = '0;
    c_b        = '0;
    c_den_next = AW'(1);
    case (layout_mode)
      MODE_STRETCH: ;
      MODE_FIT: begin
        if (bq_side.eff >= bq_side.oasp) begin
          c_side_next.op  = OP_DST_H;
          c_side_next.lim = bq_side.oh;
          c_a        = bq_side.ow;
          c_b        = ONE_Q;
          c_den_next = bq_side.eff;
        end else begin
          c_side_next.op  = OP_DST_W;
          c_side_next.lim = bq_side.ow;
          c_a        = bq_side.oh;
          c_b        = bq_side.eff;
          c_den_next = ONE_Q;
        end
      end
      default: begin
        if (bq_side.eff > bq_side.oasp) begin
          c_side_next.op  = OP_SRC_W;
          c_side_next.lim = c_side_next.sw;
          c_a        = c_side_next.sw;
          c_b        = bq_side.oasp;
          c_den_next = bq_side.eff;
        end else if (bq_side.eff < bq_side.oasp) begin
          c_side_next.op  = OP_SRC_H;
          c_side_next.lim = c_side_next.sh;
          c_a        = c_side_next.sh;
          c_b        = bq_side.eff;
          c_den_next = bq_side.oasp;
        end
      end
    endcase
  end

  logic          c_valid;
  logic [NB-1:0] c_prod;
  logic [AW-1:0] c_den;
  side_c_t       c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= bq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_prod <= NB'(c_a) * NB'(c_b);
      c_den  <= c_den_next;
      c_side <= c_side_next;
    end
  end

  logic        cq_valid, cq_ovf;
  logic [QB:0] cq;
  side_c_t     cq_side;

  vlf_div #(.NW(NB), .DW(AW), .QW(QB), .SW($bits(side_c_t))) u_div_fit (
    .clk, .rst, .adv,
    .in_valid (c_valid),
    .in_num   (c_prod),
    .in_den   (c_den),
    .in_side  (c_side),
    .out_valid(cq_valid),
    .out_q    (cq),
    .out_ovf  (cq_ovf),
    .out_side (cq_side)
  );

  // stage d: final rectangles into the output register
  logic [D-1:0] dv, sx, sy, sw, sh, dx, dy, dw, dh;

  always_comb begin
    dv = clampq(cq, cq_ovf, cq_side.lim);
    sx = cq_side.sx;
    sy = cq_side.sy;
    sw = cq_side.sw;
    sh = cq_side.sh;
    dx = '0;
    dy = '0;
    dw = cq_side.ow;
    dh = cq_side.oh;
    case (cq_side.op)
      OP_DST_H: begin
        dy = (cq_side.oh - dv) >> 1;
        dh = dv;
      end
      OP_DST_W: begin
        dx = (cq_side.ow - dv) >> 1;
        dw = dv;
      end
      OP_SRC_W: begin
        sx = sx + ((sw - dv) >> 1);
        sw = dv;
      end
      OP_SRC_H: begin
        sy = sy + ((sh - dv) >> 1);
        sh = dv;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= cq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cq_side.zero) begin
        rsp.layout_valid   <= 1'b0;
        rsp.src_x          <= '0;
        rsp.src_y          <= '0;
        rsp.src_w          <= '0;
        rsp.src_h          <= '0;
        rsp.dst_x          <= '0;
        rsp.dst_y          <= '0;
        rsp.dst_w          <= '0;
        rsp.dst_h          <= '0;
        rsp.source_cropped <= 1'b0;
      end else begin
        rsp.layout_valid   <= 1'b1;
        rsp.src_x          <= sx;
        rsp.src_y          <= sy;
        rsp.src_w          <= sw;
        rsp.src_h          <= sh;
        rsp.dst_x          <= dx;
        rsp.dst_y          <= dy;
        rsp.dst_w          <= dw;
        rsp.dst_h          <= dh;
        rsp.source_cropped <= (sx != '0) || (sy != '0) ||
                              (sw != cq_side.fw) || (sh != cq_side.fh);
      end
    end
  end

  assign rsp.valid = rsp_valid;

  // an invalid layout is all zero
  a_zero_layout: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.layout_valid |-> rsp.src_w == '0 && rsp.dst_w == '0 &&
      rsp.dst_h == '0 && !rsp.source_cropped)
    else $error("invalid layout with nonzero fields");

  // clamping never yields an empty rectangle
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.layout_valid |-> rsp.src_w != '0 && rsp.src_h != '0 &&
      rsp.dst_w != '0 && rsp.dst_h != '0)
    else $error("empty rectangle in valid layout");

  // an uncropped source starts at the frame origin
  a_uncropped_origin: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.layout_valid && !rsp.source_cropped |->
      rsp.src_x == '0 && rsp.src_y == '0)
    else $error("uncropped source with offset");

  // the two aspect divider pipelines stay in lockstep
  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    a1_valid == a2_valid)
    else $error("aspect dividers out of step");

endmodule
